// ===== rtl/rau_pkg.sv =====
// Shared definitions for the rational arithmetic unit.
// Holds widths, mode and status codes, and the controller/datapath command types.
// Depends on nothing.
package rau_pkg;

	// Width of the input and result fields.
	localparam int FW = 32;
	// Default result range width used for the overflow check.
	localparam int DEF_WIDTH = 32;
	// Width of the reduction unit (products of two field magnitudes plus a carry).
	localparam int RW = 64;
	// Bits needed to count shifts and division steps over RW.
	localparam int KW = $clog2(RW);

	// Operation codes.
	localparam logic [3:0] MODE_ADD = 4'd0;
	localparam logic [3:0] MODE_SUB = 4'd1;
	localparam logic [3:0] MODE_MUL = 4'd2;
	localparam logic [3:0] MODE_DIV = 4'd3;
	localparam logic [3:0] MODE_LT  = 4'd4;
	localparam logic [3:0] MODE_LE  = 4'd5;
	localparam logic [3:0] MODE_GT  = 4'd6;
	localparam logic [3:0] MODE_GE  = 4'd7;
	localparam logic [3:0] MODE_EQ  = 4'd8;
	localparam logic [3:0] MODE_NE  = 4'd9;
	localparam logic [3:0] MODE_NEG = 4'd10;
	localparam logic [3:0] MODE_INV = 4'd11;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ZDEN  = 2'd1;
	localparam logic [1:0] ST_DIV0  = 2'd2;
	localparam logic [1:0] ST_OVF   = 2'd3;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_RA_GO,
		OP_RA_WB,
		OP_RB_GO,
		OP_RB_WB,
		OP_RG_GO,
		OP_RG_WB,
		OP_MUL_X,
		OP_MUL_Y,
		OP_MUL_D,
		OP_FORM,
		OP_RR_GO,
		OP_RR_WB,
		OP_FIN_OK,
		OP_FIN_CMP,
		OP_FIN_NULL,
		OP_FIN_ERR1,
		OP_FIN_ERR2
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	// Status seen by the controller.
	typedef struct packed {
		logic red_done;
		logic mode_bad;
		logic binary;
		logic is_cmp;
		logic is_addsub;
		logic is_mul;
		logic is_div;
		logic is_neg;
		logic is_inv;
		logic den_zero;
		logic an_zero;
		logic bn_zero;
	} dp_stat_t;

endpackage

// ===== rtl/rau_reduce.sv =====
// Reduction unit: brings a fraction p/q to lowest terms.
// Binary gcd one step a cycle, then two restoring dividers sharing the gcd.
// Depends on rau_pkg.
module rau_reduce import rau_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [RW-1:0] p_in,
	input  logic [RW-1:0] q_in,
	output logic          done,
	output logic [RW-1:0] p_out,
	output logic [RW-1:0] q_out
);

	typedef enum logic [1:0] {R_IDLE, R_GCD, R_DIV} red_state_t;

	red_state_t    state_q;
	logic          done_q;
	logic [RW-1:0] x_q, y_q, g_q;
	logic [KW-1:0] k_q, cnt_q;
	logic [RW-1:0] dva_q, dvb_q, ra_q, rb_q;
	logic [RW-1:0] po_q, qo_q;

	logic [RW:0]   sha, shb, suba, subb;
	logic          bita, bitb;
	logic [RW-1:0] nra, nrb, nda, ndb;

	// One restoring division step for each of the two dividends.
	always_comb begin
		sha  = {ra_q, dva_q[RW-1]};
		shb  = {rb_q, dvb_q[RW-1]};
		suba = sha - {1'b0, g_q};
		subb = shb - {1'b0, g_q};
		bita = !suba[RW];
		bitb = !subb[RW];
		nra  = bita ? suba[RW-1:0] : sha[RW-1:0];
		nrb  = bitb ? subb[RW-1:0] : shb[RW-1:0];
		nda  = {dva_q[RW-2:0], bita};
		ndb  = {dvb_q[RW-2:0], bitb};
	end

	// Sequencer for the gcd and the division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (start) begin
						if (p_in == '0) begin
							po_q   <= '0;
							qo_q   <= RW'(1);
							done_q <= 1'b1;
						end else begin
							x_q     <= p_in;
							y_q     <= q_in;
							dva_q   <= p_in;
							dvb_q   <= q_in;
							k_q     <= '0;
							state_q <= R_GCD;
						end
					end
				end
				R_GCD: begin
					if (x_q == y_q) begin
						g_q     <= x_q << k_q;
						ra_q    <= '0;
						rb_q    <= '0;
						cnt_q   <= '0;
						state_q <= R_DIV;
					end else if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + KW'(1);
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q > y_q) begin
						x_q <= (x_q - y_q) >> 1;
					end else begin
						y_q <= (y_q - x_q) >> 1;
					end
				end
				R_DIV: begin
					ra_q  <= nra;
					rb_q  <= nrb;
					dva_q <= nda;
					dvb_q <= ndb;
					cnt_q <= cnt_q + KW'(1);
					if (cnt_q == KW'(RW - 1)) begin
						po_q    <= nda;
						qo_q    <= ndb;
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign p_out = po_q;
	assign q_out = qo_q;

endmodule

// ===== rtl/rau_datapath.sv =====
// Datapath of the rational arithmetic unit: operand registers, multiplier,
// signed add, comparison, range check and result registers. Depends on rau_pkg, rau_reduce.
module rau_datapath import rau_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic [3:0]           mode,
	input  logic signed [FW-1:0] a_num,
	input  logic signed [FW-1:0] a_den,
	input  logic signed [FW-1:0] b_num,
	input  logic signed [FW-1:0] b_den,
	output logic signed [FW-1:0] res_num,
	output logic [FW-2:0]        res_den,
	output logic                 cmp_true,
	output logic [1:0]           status
);

	localparam logic [RW-1:0] LIM = (RW'(1) << (WIDTH - 1)) - RW'(1);

	logic [3:0]    mode_q;
	logic [FW-1:0] an_q, ad_q, bn_q, bd_q, t1_q, t2_q;
	logic          ann_q, bnn_q, rnn_q;
	logic [RW-1:0] x_q, y_q, rn_q, rd_q;
	logic signed [FW-1:0] res_num_q;
	logic [FW-2:0] res_den_q;
	logic          cmp_q;
	logic [1:0]    status_q;

	logic          red_start, red_done;
	logic [RW-1:0] red_p, red_q, red_po, red_qo;
	logic [FW-1:0] ma, mb;
	logic [RW-1:0] prod;
	logic          is_cmp, is_addsub, binary;
	logic          yneg, sum_neg;
	logic [RW-1:0] sum_mag;
	logic          lneg, rneg, c_lt, c_eq, c_true, ovf;

	function automatic logic [FW-1:0] fmag(input logic [FW-1:0] v);
		fmag = v[FW-1] ? (~v + FW'(1)) : v;
	endfunction

	assign is_cmp    = (mode_q >= MODE_LT) && (mode_q <= MODE_NE);
	assign is_addsub = (mode_q == MODE_ADD) || (mode_q == MODE_SUB);
	assign binary    = mode_q <= MODE_NE;

	// Status toward the controller.
	always_comb begin
		stat.red_done  = red_done;
		stat.mode_bad  = mode_q > MODE_INV;
		stat.binary    = binary;
		stat.is_cmp    = is_cmp;
		stat.is_addsub = is_addsub;
		stat.is_mul    = mode_q == MODE_MUL;
		stat.is_div    = mode_q == MODE_DIV;
		stat.is_neg    = mode_q == MODE_NEG;
		stat.is_inv    = mode_q == MODE_INV;
		stat.den_zero  = (ad_q == '0) || (binary && (bd_q == '0));
		stat.an_zero   = an_q == '0;
		stat.bn_zero   = bn_q == '0;
	end

	// Operand selection for the reduction unit.
	always_comb begin
		red_start = 1'b0;
		red_p     = RW'(an_q);
		red_q     = RW'(ad_q);
		case (cmd.op)
			OP_RA_GO: red_start = 1'b1;
			OP_RB_GO: begin
				red_start = 1'b1;
				red_p     = RW'(bn_q);
				red_q     = RW'(bd_q);
			end
			OP_RG_GO: begin
				red_start = 1'b1;
				red_p     = RW'(ad_q);
				red_q     = RW'(bd_q);
			end
			OP_RR_GO: begin
				red_start = 1'b1;
				red_p     = rn_q;
				red_q     = rd_q;
			end
			default: ;
		endcase
	end

	rau_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.p_in   (red_p),
		.q_in   (red_q),
		.done   (red_done),
		.p_out  (red_po),
		.q_out  (red_qo)
	);

	// Multiplier operand selection; the product is registered.
	always_comb begin
		ma = an_q;
		mb = bd_q;
		case (cmd.op)
			OP_MUL_X: begin
				if (is_addsub) mb = t2_q;
				else if (mode_q == MODE_MUL) mb = bn_q;
			end
			OP_MUL_Y: begin
				if (is_addsub) begin
					ma = bn_q;
					mb = t1_q;
				end else if (mode_q == MODE_MUL) begin
					ma = ad_q;
					mb = bd_q;
				end else if (mode_q == MODE_DIV) begin
					ma = ad_q;
					mb = bn_q;
				end else begin
					ma = bn_q;
					mb = ad_q;
				end
			end
			OP_MUL_D: begin
				ma = t1_q;
				mb = bd_q;
			end
			default: ;
		endcase
		prod = RW'(ma) * RW'(mb);
	end

	// Signed sum of the two scaled numerators.
	always_comb begin
		yneg = bnn_q ^ ((mode_q == MODE_SUB) && (bn_q != '0));
		if (ann_q == yneg) begin
			sum_neg = ann_q;
			sum_mag = x_q + y_q;
		end else if (x_q >= y_q) begin
			sum_neg = ann_q;
			sum_mag = x_q - y_q;
		end else begin
			sum_neg = yneg;
			sum_mag = y_q - x_q;
		end
		if (sum_mag == '0) sum_neg = 1'b0;
	end

	// Comparison of the cross products and the range check.
	always_comb begin
		lneg = ann_q && (x_q != '0);
		rneg = bnn_q && (y_q != '0);
		c_eq = (lneg == rneg) && (x_q == y_q);
		if (lneg != rneg) c_lt = lneg;
		else if (lneg) c_lt = x_q > y_q;
		else c_lt = x_q < y_q;
		case (mode_q)
			MODE_LT: c_true = c_lt;
			MODE_LE: c_true = c_lt || c_eq;
			MODE_GT: c_true = !c_lt && !c_eq;
			MODE_GE: c_true = !c_lt;
			MODE_EQ: c_true = c_eq;
			default: c_true = !c_eq;
		endcase
		ovf = (rd_q > LIM) || (!rnn_q && (rn_q > LIM)) ||
			(rnn_q && ((rn_q - RW'(1)) > LIM));
	end

	// Register updates for each datapath operation.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mode_q <= mode;
				an_q   <= fmag(a_num);
				ad_q   <= fmag(a_den);
				bn_q   <= fmag(b_num);
				bd_q   <= fmag(b_den);
				ann_q  <= a_num[FW-1] ^ a_den[FW-1];
				bnn_q  <= b_num[FW-1] ^ b_den[FW-1];
			end
			OP_RA_WB: begin
				an_q <= red_po[FW-1:0];
				ad_q <= red_qo[FW-1:0];
				if (red_po == '0) ann_q <= 1'b0;
			end
			OP_RB_WB: begin
				bn_q <= red_po[FW-1:0];
				bd_q <= red_qo[FW-1:0];
				if (red_po == '0) bnn_q <= 1'b0;
			end
			OP_RG_WB: begin
				t1_q <= red_po[FW-1:0];
				t2_q <= red_qo[FW-1:0];
			end
			OP_MUL_X: x_q <= prod;
			OP_MUL_Y: y_q <= prod;
			OP_MUL_D: rd_q <= prod;
			OP_FORM: begin
				if (is_addsub) begin
					rn_q  <= sum_mag;
					rnn_q <= sum_neg;
				end else if (mode_q == MODE_NEG) begin
					rn_q  <= RW'(an_q);
					rnn_q <= !ann_q;
					rd_q  <= RW'(ad_q);
				end else if (mode_q == MODE_INV) begin
					rn_q  <= RW'(ad_q);
					rnn_q <= ann_q;
					rd_q  <= RW'(an_q);
				end else begin
					rn_q  <= x_q;
					rnn_q <= ann_q ^ bnn_q;
					rd_q  <= y_q;
				end
			end
			OP_RR_WB: begin
				rn_q <= red_po;
				rd_q <= red_qo;
				if (red_po == '0) rnn_q <= 1'b0;
			end
			OP_FIN_OK: begin
				res_num_q <= rnn_q ? -rn_q[FW-1:0] : rn_q[FW-1:0];
				res_den_q <= rd_q[FW-2:0];
				cmp_q     <= 1'b0;
				status_q  <= ovf ? ST_OVF : ST_OK;
			end
			OP_FIN_CMP: begin
				res_num_q <= '0;
				res_den_q <= (FW-1)'(1);
				cmp_q     <= c_true;
				status_q  <= ST_OK;
			end
			OP_FIN_NULL, OP_FIN_ERR1, OP_FIN_ERR2: begin
				res_num_q <= '0;
				res_den_q <= (FW-1)'(1);
				cmp_q     <= 1'b0;
				if (cmd.op == OP_FIN_ERR1) status_q <= ST_ZDEN;
				else if (cmd.op == OP_FIN_ERR2) status_q <= ST_DIV0;
				else status_q <= ST_OK;
			end
			default: ;
		endcase
	end

	assign res_num  = res_num_q;
	assign res_den  = res_den_q;
	assign cmp_true = cmp_q;
	assign status   = status_q;

endmodule

// ===== rtl/rau_ctrl.sv =====
// Controller of the rational arithmetic unit: sequences one transaction
// through the datapath. Depends on rau_pkg.
module rau_ctrl import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_RA, S_RA_W, S_RB, S_RB_W, S_DISP, S_RG, S_RG_W,
		S_MX, S_MY, S_MD, S_FORM, S_RR, S_RR_W, S_FIN
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic        done_q, done_d;

	// Next state, finish flag and datapath command.
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.mode_bad) begin
					cmd.op  = OP_FIN_NULL;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (stat.den_zero) begin
					cmd.op  = OP_FIN_ERR1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_RA;
				end
			end
			S_RA: begin
				cmd.op  = OP_RA_GO;
				state_d = S_RA_W;
			end
			S_RA_W: begin
				if (stat.red_done) begin
					cmd.op  = OP_RA_WB;
					state_d = stat.binary ? S_RB : S_DISP;
				end
			end
			S_RB: begin
				cmd.op  = OP_RB_GO;
				state_d = S_RB_W;
			end
			S_RB_W: begin
				if (stat.red_done) begin
					cmd.op  = OP_RB_WB;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if ((stat.is_div && stat.bn_zero) || (stat.is_inv && stat.an_zero)) begin
					cmd.op  = OP_FIN_ERR2;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (stat.is_addsub) begin
					state_d = S_RG;
				end else if (stat.is_neg || stat.is_inv) begin
					state_d = S_FORM;
				end else begin
					state_d = S_MX;
				end
			end
			S_RG: begin
				cmd.op  = OP_RG_GO;
				state_d = S_RG_W;
			end
			S_RG_W: begin
				if (stat.red_done) begin
					cmd.op  = OP_RG_WB;
					state_d = S_MX;
				end
			end
			S_MX: begin
				cmd.op  = OP_MUL_X;
				state_d = S_MY;
			end
			S_MY: begin
				cmd.op = OP_MUL_Y;
				if (stat.is_cmp) state_d = S_FIN;
				else if (stat.is_addsub) state_d = S_MD;
				else state_d = S_FORM;
			end
			S_MD: begin
				cmd.op  = OP_MUL_D;
				state_d = S_FORM;
			end
			S_FORM: begin
				cmd.op  = OP_FORM;
				state_d = S_RR;
			end
			S_RR: begin
				cmd.op  = OP_RR_GO;
				state_d = S_RR_W;
			end
			S_RR_W: begin
				if (stat.red_done) begin
					cmd.op  = OP_RR_WB;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.op  = stat.is_cmp ? OP_FIN_CMP : OP_FIN_OK;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and the registered result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit.
// Joins the controller and the datapath. Depends on rau_pkg, rau_ctrl, rau_datapath.
//
// A transaction is taken when start is high and busy is low; the result shows
// on res_num, res_den, cmp_true and status for one cycle with done high, and the
// receiver cannot stall it. For a bad mode or a zero denominator the strobe is
// raised from the check state; other modes wait on lowest-terms reductions in the
// shared reduction unit. Each runs binary gcd steps (up to about 64 on an input
// fraction or the denominators, about 128 on the final result), a restoring
// division step per bit of RW and a handoff; a zero numerator skips gcd and
// division. Input a, input b (except for negate and invert) and the result (except
// for comparisons) are each reduced, and add or subtract reduce the two
// denominators as well. A new transaction is taken in the cycle of done.
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	input  logic [3:0]           mode,
	input  logic signed [FW-1:0] a_num,
	input  logic signed [FW-1:0] a_den,
	input  logic signed [FW-1:0] b_num,
	input  logic signed [FW-1:0] b_den,
	output logic signed [FW-1:0] res_num,
	output logic [FW-2:0]        res_den,
	output logic                 cmp_true,
	output logic [1:0]           status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	rau_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.mode     (mode),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.res_num  (res_num),
		.res_den  (res_den),
		.cmp_true (cmp_true),
		.status   (status)
	);

endmodule

// ===== rtl/rau_checker.sv =====
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit.
module rau_checker import rau_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic signed [FW-1:0] res_num,
	input logic [FW-2:0]        res_den,
	input logic                 cmp_true,
	input logic [1:0]           status
);

	// An accepted transaction makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transaction did not raise busy");

	// A result is shown only once the block is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	// A result strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");

	// A true comparison carries the neutral fraction and no error.
	a_cmp_form: assert property (@(posedge clk) disable iff (!arst_n)
		done && cmp_true |-> res_num == 0 && res_den == 1 && status == ST_OK)
		else $error("comparison result malformed");

	// Input errors give zero over one.
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_ZDEN || status == ST_DIV0) |->
		res_num == 0 && res_den == 1 && !cmp_true)
		else $error("error result malformed");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.res_num  (res_num),
	.res_den  (res_den),
	.cmp_true (cmp_true),
	.status   (status)
);

// ===== tb/tb_rational_arithmetic_unit.sv =====
// Testbench for the rational arithmetic unit: drives fraction operations and checks
// each result against a behavioral predictor of exact, reduced rational arithmetic.
// Depends on rau_pkg and rational_arithmetic_unit.
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit;
	import rau_pkg::*;

	typedef struct packed {
		logic [3:0]  mode;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic [31:0] b_num;
		logic [31:0] b_den;
	} op_item_t;

	typedef struct packed {
		logic [31:0] num;
		logic [30:0] den;
		logic        cmp;
		logic [1:0]  st;
	} fraction_result_t;

	localparam longint CYCLE_LIMIT = 10000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	logic [3:0]  mode;
	logic signed [31:0] a_num;
	logic signed [31:0] a_den;
	logic signed [31:0] b_num;
	logic signed [31:0] b_den;
	logic signed [31:0] res_num;
	logic [30:0] res_den;
	logic        cmp_true;
	logic [1:0]  status;

	op_item_t         pending_ops[$];
	fraction_result_t expected_results[$];
	int               gap_left;
	int               errors;
	longint           cycles;
	bit               stim_done;
	bit               hold_for_drain;

	rational_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.mode(mode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.res_num(res_num), .res_den(res_den), .cmp_true(cmp_true), .status(status)
	);

	// Clock: 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Split a 32-bit field into sign and magnitude.
	function automatic void to_sign_mag(input logic [31:0] v, output bit s,
			output logic [63:0] m);
		s = v[31];
		m = s ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
	endfunction

	function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Bring num/den to lowest terms; zero becomes 0/1.
	function automatic void lowest_terms(inout bit s, inout logic [63:0] n,
			inout logic [63:0] d);
		logic [63:0] g;
		if (n == 0) begin
			s = 0;
			d = 1;
		end else begin
			g = gcd64(n, d);
			n = n / g;
			d = d / g;
		end
	endfunction

	// Expected result of one operation on two fractions.
	function automatic fraction_result_t predict_fraction(input op_item_t it);
		fraction_result_t r;
		bit an_s, ad_s, bn_s, bd_s, rs, xs, ys;
		logic [63:0] an, ad, bn, bd, rn, rd, g, xm, ym, lim;
		bit binop, lt, eq;
		r = '{num: 0, den: 1, cmp: 0, st: ST_OK};
		binop = it.mode <= MODE_NE;
		to_sign_mag(it.a_num, an_s, an);
		to_sign_mag(it.a_den, ad_s, ad);
		to_sign_mag(it.b_num, bn_s, bn);
		to_sign_mag(it.b_den, bd_s, bd);
		if (it.mode > MODE_INV)
			return r;
		if (ad == 0 || (binop && bd == 0)) begin
			r.st = ST_ZDEN;
			return r;
		end
		an_s = an_s ^ ad_s;
		lowest_terms(an_s, an, ad);
		bn_s = bn_s ^ bd_s;
		if (binop)
			lowest_terms(bn_s, bn, bd);
		// Comparisons by cross-multiplication with positive denominators.
		if (it.mode >= MODE_LT && it.mode <= MODE_NE) begin
			xm = an * bd;
			ym = bn * ad;
			xs = (xm == 0) ? 0 : an_s;
			ys = (ym == 0) ? 0 : bn_s;
			eq = (xs == ys) && (xm == ym);
			if (xs != ys)
				lt = xs;
			else
				lt = xs ? (xm > ym) : (xm < ym);
			case (it.mode)
				MODE_LT: r.cmp = lt;
				MODE_LE: r.cmp = lt || eq;
				MODE_GT: r.cmp = !lt && !eq;
				MODE_GE: r.cmp = !lt;
				MODE_EQ: r.cmp = eq;
				default: r.cmp = !eq;
			endcase
			return r;
		end
		case (it.mode)
			MODE_ADD, MODE_SUB: begin
				g = gcd64(ad, bd);
				ys = bn_s;
				if (it.mode == MODE_SUB && bn != 0)
					ys = !ys;
				xm = an * (bd / g);
				ym = bn * (ad / g);
				if (an_s == ys) begin
					rs = an_s;
					rn = xm + ym;
				end else if (xm >= ym) begin
					rs = an_s;
					rn = xm - ym;
				end else begin
					rs = ys;
					rn = ym - xm;
				end
				if (rn == 0)
					rs = 0;
				rd = (ad / g) * bd;
			end
			MODE_MUL: begin
				rs = an_s ^ bn_s;
				rn = an * bn;
				rd = ad * bd;
			end
			MODE_DIV: begin
				if (bn == 0) begin
					r.st = ST_DIV0;
					return r;
				end
				rs = an_s ^ bn_s;
				rn = an * bd;
				rd = ad * bn;
			end
			MODE_NEG: begin
				rs = !an_s;
				rn = an;
				rd = ad;
			end
			default: begin
				if (an == 0) begin
					r.st = ST_DIV0;
					return r;
				end
				rs = an_s;
				rn = ad;
				rd = an;
			end
		endcase
		lowest_terms(rs, rn, rd);
		lim = 64'h7FFF_FFFF;
		r.num = rs ? 32'(64'd0 - rn) : rn[31:0];
		r.den = rd[30:0];
		if (rd > lim || (!rs && rn > lim) || (rs && rn - 1 > lim))
			r.st = ST_OVF;
		return r;
	endfunction

	// Random field value: mostly small numbers, sometimes extremes or full range.
	function automatic logic [31:0] pick_field();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			3: return 32'($urandom_range(0, 65535)) * (($urandom_range(0, 1) != 0) ? -1 : 1);
			4: return 32'($urandom_range(0, 2)) - 1;
			default: return 32'($urandom_range(0, 40)) - 20;
		endcase
	endfunction

	function automatic logic [31:0] pick_den();
		logic [31:0] v;
		v = pick_field();
		if (v == 0 && $urandom_range(0, 3) != 0)
			v = 1;
		return v;
	endfunction

	// Stimulus: directed cases first, then random items.
	initial begin
		op_item_t it;
		logic [31:0] ext[6];
		ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'h8000_0001};
		errors = 0;
		cycles = 0;
		stim_done = 0;
		hold_for_drain = 0;
		for (int m = 0; m < 16; m++)
			pending_ops.push_back('{4'(m), 32'd6, -32'sd4, 32'd3, 32'd9});
		pending_ops.push_back('{MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd1});
		pending_ops.push_back('{MODE_ADD, 32'd1, 32'd1, 32'd1, 32'd0});
		pending_ops.push_back('{MODE_NEG, 32'd1, 32'd1, 32'd5, 32'd0});
		pending_ops.push_back('{MODE_DIV, 32'd3, 32'd7, 32'd0, -32'sd5});
		pending_ops.push_back('{MODE_INV, 32'd0, 32'd7, 32'd1, 32'd1});
		pending_ops.push_back('{MODE_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd1});
		pending_ops.push_back('{MODE_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1});
		pending_ops.push_back('{MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF});
		pending_ops.push_back('{MODE_INV, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'd0});
		for (int k = 0; k < 1830; k++) begin
			it.mode = ($urandom_range(0, 40) == 0) ? 4'($urandom_range(12, 15))
				: 4'($urandom_range(0, 11));
			it.a_num = pick_field();
			it.a_den = pick_den();
			it.b_num = pick_field();
			it.b_den = pick_den();
			if ($urandom_range(0, 15) == 0)
				it.a_num = ext[$urandom_range(0, 5)];
			pending_ops.push_back(it);
		end
	end

	// Reset and cycle limit.
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("rational_arithmetic_unit: mismatch");
			$finish;
		end
	end

	// Driver: one transaction from the queue, with a random gap before each.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= '0;
			a_num <= '0;
			a_den <= '0;
			b_num <= '0;
			b_den <= '0;
			gap_left <= $urandom_range(0, 7);
		end else if (start && !busy) begin
			expected_results.push_back(predict_fraction({mode, a_num, a_den, b_num, b_den}));
			start <= 1'b0;
			gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
		end else if (!start) begin
			if (pending_ops.size() == 900 && !hold_for_drain)
				hold_for_drain <= 1'b1;
			if (hold_for_drain && expected_results.size() == 0)
				hold_for_drain <= 1'b0;
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (!hold_for_drain && pending_ops.size() > 0) begin
				{mode, a_num, a_den, b_num, b_den} <= pending_ops.pop_front();
				start <= 1'b1;
				if (pending_ops.size() == 900)
					hold_for_drain <= 1'b1;
			end else if (pending_ops.size() == 0) begin
				stim_done <= 1'b1;
			end
		end
	end

	// Monitor: compare each result with the oldest expectation.
	always @(posedge clk) begin
		fraction_result_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no transaction pending", $time);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (exp_r.num !== res_num) begin
					$display("%0t: res_num expected %0d actual %0d", $time,
						$signed(exp_r.num), res_num);
					errors++;
				end
				if (exp_r.den !== res_den) begin
					$display("%0t: res_den expected %0d actual %0d", $time, exp_r.den, res_den);
					errors++;
				end
				if (exp_r.cmp !== cmp_true) begin
					$display("%0t: cmp_true expected %0b actual %0b", $time, exp_r.cmp, cmp_true);
					errors++;
				end
				if (exp_r.st !== status) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
					errors++;
				end
			end
		end
	end

	// End of run: drain, wait out the latency, then report.
	initial begin
		wait (stim_done);
		wait (expected_results.size() == 0);
		repeat (800) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("rational_arithmetic_unit: match");
		else
			$display("rational_arithmetic_unit: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rau_pkg.sv
rtl/rau_reduce.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
tb/tb_rational_arithmetic_unit.sv
